// File: rtl/core/time_weighted_activity_stats_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the activity statistics block
// Both macros check on the rising clock edge and hold off while reset is high.
// ----------------------------------------------------------------------------
`ifndef TIME_WEIGHTED_ACTIVITY_STATS_TOP_MACROS_SVH
`define TIME_WEIGHTED_ACTIVITY_STATS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TWAS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("twas assertion failed");
`define TWAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("twas assertion failed");
`else
`define TWAS_ASSERT_IMPL(label, ante, cons)
`define TWAS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/twas_pkg.sv
// ----------------------------------------------------------------------------
// Activity statistics package
// Shared codes, widths, handshake structs and saturating adders.
// ----------------------------------------------------------------------------
package twas_pkg;

   localparam int SUM_W    = 64;
   localparam int TOT_W    = 32;
   localparam int QUOT_W   = 16;
   localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_STOP   = 2'd2;

   localparam logic [1:0] SESS_IDLE = 2'd0;
   localparam logic [1:0] SESS_REC  = 2'd1;
   localparam logic [1:0] SESS_STOP = 2'd2;

   localparam logic [1:0] MUL_SPEED = 2'd0;
   localparam logic [1:0] MUL_RATE  = 2'd1;
   localparam logic [1:0] MUL_POWER = 2'd2;
   localparam logic [1:0] MUL_LAST  = 2'd3;

   localparam logic [1:0] MEAN_SPEED = 2'd0;
   localparam logic [1:0] MEAN_RATE  = 2'd1;
   localparam logic [1:0] MEAN_POWER = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MUL     = 5'b00010,
      ST_DIVGO   = 5'b00100,
      ST_DIVWAIT = 5'b01000,
      ST_DONE    = 5'b10000
   } seq_state_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [TOT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [TOT_W-1:0] sat_add32(input logic [TOT_W-1:0] a,
                                                   input logic [TOT_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOT_W] ? '1 : s[TOT_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                   input logic [TOT_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W-TOT_W+1){1'b0}}, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

endpackage

// File: rtl/core/time_weighted_activity_stats_top.sv
// Start, stop and rejected items pass from acceptance to the done state, then to the result register.
// An update passes through the shared multiplier and adder, then up to three
// serial 16-step divisions in the shared divider.
// One item is in work at a time; a new item is taken while a result waits.
// Reset is synchronous and active high; it clears the session to idle and zero.
// ----------------------------------------------------------------------------
// Activity statistics top level
// Session sequencer with saturating totals, time-weighted sums, peaks and means.
// ----------------------------------------------------------------------------
`include "time_weighted_activity_stats_top_macros.svh"

module time_weighted_activity_stats_top
   import twas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic signed [15:0] req_step_ms,
   input  logic [15:0] req_speed_in,
   input  logic [15:0] req_rate_in,
   input  logic [15:0] req_power_in,
   input  logic [15:0] req_distance_step,
   input  logic [15:0] req_stroke_step,
   input  logic        req_speed_ok,
   input  logic        req_rate_ok,
   input  logic [31:0] req_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [1:0]  rsp_session_state,
   output logic [31:0] rsp_total_distance,
   output logic [31:0] rsp_total_strokes,
   output logic [31:0] rsp_duration,
   output logic [15:0] rsp_peak_speed,
   output logic [15:0] rsp_peak_rate,
   output logic [15:0] rsp_mean_speed,
   output logic [15:0] rsp_mean_rate,
   output logic [15:0] rsp_mean_power,
   output logic [31:0] rsp_began_at,
   output logic [31:0] rsp_ended_at
);

   seq_state_type state_ff, state_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [1:0]    idx_ff, idx_in;
   logic          status_ff, status_in;

   logic [14:0]   dt_ff, dt_in;
   logic [15:0]   spd_ff, spd_in, rte_ff, rte_in, pwr_ff, pwr_in;
   logic [15:0]   dist_ff, dist_in, strk_ff, strk_in;
   logic          sok_ff, sok_in, rok_ff, rok_in;
   logic [30:0]   prod_ff, prod_in;

   logic [1:0]       run_state_ff, run_state_in;
   logic [TOT_W-1:0] dist_tot_ff, dist_tot_in, strk_tot_ff, strk_tot_in;
   logic [TOT_W-1:0] time_tot_ff, time_tot_in;
   logic [TOT_W-1:0] spd_time_ff, spd_time_in, rte_time_ff, rte_time_in;
   logic [SUM_W-1:0] spd_sum_ff, spd_sum_in, rte_sum_ff, rte_sum_in;
   logic [SUM_W-1:0] pwr_sum_ff, pwr_sum_in;
   logic [15:0]      spd_peak_ff, spd_peak_in, rte_peak_ff, rte_peak_in;
   logic [15:0]      spd_mean_ff, spd_mean_in, rte_mean_ff, rte_mean_in;
   logic [15:0]      pwr_mean_ff, pwr_mean_in;
   logic [TOT_W-1:0] began_ff, began_in, ended_ff, ended_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff;
   logic [1:0]       rsp_state_ff;
   logic [TOT_W-1:0] rsp_dist_ff, rsp_strk_ff, rsp_dur_ff, rsp_began_ff, rsp_ended_ff;
   logic [15:0]      rsp_spk_ff, rsp_rpk_ff, rsp_smean_ff, rsp_rmean_ff, rsp_pmean_ff;

   logic             req_accept;
   logic             rsp_load;
   logic [15:0]      mul_a;
   logic [30:0]      mul_full;
   logic [TOT_W-1:0] div_weight;
   logic [SUM_W-1:0] div_sum;
   logic [TOT_W-1:0] dt_ext;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign dt_ext     = {{(TOT_W-15){1'b0}}, dt_ff};

   always_comb begin
      unique case (cnt_ff)
         MUL_SPEED: mul_a = spd_ff;
         MUL_RATE:  mul_a = rte_ff;
         default:   mul_a = pwr_ff;
      endcase
   end

   assign mul_full = 31'(mul_a) * 31'(dt_ff);

   always_comb begin
      unique case (idx_ff)
         MEAN_SPEED: begin
            div_weight = spd_time_ff;
            div_sum    = spd_sum_ff;
         end
         MEAN_RATE: begin
            div_weight = rte_time_ff;
            div_sum    = rte_sum_ff;
         end
         default: begin
            div_weight = time_tot_ff;
            div_sum    = pwr_sum_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      dt_in        = dt_ff;
      spd_in       = spd_ff;
      rte_in       = rte_ff;
      pwr_in       = pwr_ff;
      dist_in      = dist_ff;
      strk_in      = strk_ff;
      sok_in       = sok_ff;
      rok_in       = rok_ff;
      prod_in      = prod_ff;
      run_state_in = run_state_ff;
      dist_tot_in  = dist_tot_ff;
      strk_tot_in  = strk_tot_ff;
      time_tot_in  = time_tot_ff;
      spd_time_in  = spd_time_ff;
      rte_time_in  = rte_time_ff;
      spd_sum_in   = spd_sum_ff;
      rte_sum_in   = rte_sum_ff;
      pwr_sum_in   = pwr_sum_ff;
      spd_peak_in  = spd_peak_ff;
      rte_peak_in  = rte_peak_ff;
      spd_mean_in  = spd_mean_ff;
      rte_mean_in  = rte_mean_ff;
      pwr_mean_in  = pwr_mean_ff;
      began_in     = began_ff;
      ended_in     = ended_ff;
      div_req.start    = 1'b0;
      div_req.dividend = div_sum;
      div_req.divisor  = div_weight;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dt_in   = req_step_ms[15] ? '0 : req_step_ms[14:0];
               spd_in  = req_speed_in;
               rte_in  = req_rate_in;
               pwr_in  = req_power_in;
               dist_in = req_distance_step;
               strk_in = req_stroke_step;
               sok_in  = req_speed_ok;
               rok_in  = req_rate_ok;
               status_in = 1'b0;
               priority if (req_operation == OP_START) begin
                  dist_tot_in  = '0;
                  strk_tot_in  = '0;
                  time_tot_in  = '0;
                  spd_time_in  = '0;
                  rte_time_in  = '0;
                  spd_sum_in   = '0;
                  rte_sum_in   = '0;
                  pwr_sum_in   = '0;
                  spd_peak_in  = '0;
                  rte_peak_in  = '0;
                  spd_mean_in  = '0;
                  rte_mean_in  = '0;
                  pwr_mean_in  = '0;
                  ended_in     = '0;
                  began_in     = req_stamp;
                  run_state_in = SESS_REC;
                  state_in     = ST_DONE;
               end else if (req_operation == OP_UPDATE && run_state_ff == SESS_REC) begin
                  cnt_in   = MUL_SPEED;
                  state_in = ST_MUL;
               end else if (req_operation == OP_STOP && run_state_ff == SESS_REC) begin
                  ended_in     = req_stamp;
                  run_state_in = SESS_STOP;
                  state_in     = ST_DONE;
               end else begin
                  status_in = 1'b1;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            prod_in = mul_full;
            cnt_in  = cnt_ff + 1'b1;
            unique case (cnt_ff)
               MUL_SPEED: begin
                  dist_tot_in = sat_add32(dist_tot_ff, {16'd0, dist_ff});
                  strk_tot_in = sat_add32(strk_tot_ff, {16'd0, strk_ff});
                  time_tot_in = sat_add32(time_tot_ff, dt_ext);
                  if (sok_ff) begin
                     spd_time_in = sat_add32(spd_time_ff, dt_ext);
                     if (spd_ff > spd_peak_ff) begin
                        spd_peak_in = spd_ff;
                     end
                  end
                  if (rok_ff) begin
                     rte_time_in = sat_add32(rte_time_ff, dt_ext);
                     if (rte_ff > rte_peak_ff) begin
                        rte_peak_in = rte_ff;
                     end
                  end
               end
               MUL_RATE: begin
                  if (sok_ff) begin
                     spd_sum_in = sat_add64(spd_sum_ff, {1'b0, prod_ff});
                  end
               end
               MUL_POWER: begin
                  if (rok_ff) begin
                     rte_sum_in = sat_add64(rte_sum_ff, {1'b0, prod_ff});
                  end
               end
               default: begin
                  pwr_sum_in = sat_add64(pwr_sum_ff, {1'b0, prod_ff});
                  idx_in     = MEAN_SPEED;
                  state_in   = ST_DIVGO;
               end
            endcase
         end
         ST_DIVGO: begin
            if (div_weight[TOT_W-1:1] == '0) begin
               if (idx_ff == MEAN_POWER) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: begin
            if (div_rsp.done) begin
               unique case (idx_ff)
                  MEAN_SPEED: spd_mean_in = div_rsp.quotient;
                  MEAN_RATE:  rte_mean_in = div_rsp.quotient;
                  default:    pwr_mean_in = div_rsp.quotient;
               endcase
               if (idx_ff == MEAN_POWER) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_DIVGO;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   twas_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         run_state_ff <= SESS_IDLE;
         dist_tot_ff  <= '0;
         strk_tot_ff  <= '0;
         time_tot_ff  <= '0;
         spd_time_ff  <= '0;
         rte_time_ff  <= '0;
         spd_sum_ff   <= '0;
         rte_sum_ff   <= '0;
         pwr_sum_ff   <= '0;
         spd_peak_ff  <= '0;
         rte_peak_ff  <= '0;
         spd_mean_ff  <= '0;
         rte_mean_ff  <= '0;
         pwr_mean_ff  <= '0;
         began_ff     <= '0;
         ended_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         run_state_ff <= run_state_in;
         dist_tot_ff  <= dist_tot_in;
         strk_tot_ff  <= strk_tot_in;
         time_tot_ff  <= time_tot_in;
         spd_time_ff  <= spd_time_in;
         rte_time_ff  <= rte_time_in;
         spd_sum_ff   <= spd_sum_in;
         rte_sum_ff   <= rte_sum_in;
         pwr_sum_ff   <= pwr_sum_in;
         spd_peak_ff  <= spd_peak_in;
         rte_peak_ff  <= rte_peak_in;
         spd_mean_ff  <= spd_mean_in;
         rte_mean_ff  <= rte_mean_in;
         pwr_mean_ff  <= pwr_mean_in;
         began_ff     <= began_in;
         ended_ff     <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dt_ff     <= dt_in;
      spd_ff    <= spd_in;
      rte_ff    <= rte_in;
      pwr_ff    <= pwr_in;
      dist_ff   <= dist_in;
      strk_ff   <= strk_in;
      sok_ff    <= sok_in;
      rok_ff    <= rok_in;
      prod_ff   <= prod_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_state_ff  <= run_state_ff;
         rsp_dist_ff   <= dist_tot_ff;
         rsp_strk_ff   <= strk_tot_ff;
         rsp_dur_ff    <= time_tot_ff;
         rsp_spk_ff    <= spd_peak_ff;
         rsp_rpk_ff    <= rte_peak_ff;
         rsp_smean_ff  <= spd_mean_ff;
         rsp_rmean_ff  <= rte_mean_ff;
         rsp_pmean_ff  <= pwr_mean_ff;
         rsp_began_ff  <= began_ff;
         rsp_ended_ff  <= ended_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_session_state  = rsp_state_ff;
   assign rsp_total_distance = rsp_dist_ff;
   assign rsp_total_strokes  = rsp_strk_ff;
   assign rsp_duration       = rsp_dur_ff;
   assign rsp_peak_speed     = rsp_spk_ff;
   assign rsp_peak_rate      = rsp_rpk_ff;
   assign rsp_mean_speed     = rsp_smean_ff;
   assign rsp_mean_rate      = rsp_rmean_ff;
   assign rsp_mean_power     = rsp_pmean_ff;
   assign rsp_began_at       = rsp_began_ff;
   assign rsp_ended_at       = rsp_ended_ff;

   `TWAS_ASSERT_IMPL(a_div_done_when_waiting, div_rsp.done, state_ff == ST_DIVWAIT)
   `TWAS_ASSERT_NEXT(a_start_clears, req_accept && req_operation == OP_START, run_state_ff == SESS_REC && dist_tot_ff == '0)
   `TWAS_ASSERT_NEXT(a_means_hold, !req_accept && state_ff != ST_DIVWAIT, $stable(spd_mean_ff) && $stable(pwr_mean_ff))
   `TWAS_ASSERT_IMPL(a_result_from_done, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))

endmodule

// File: rtl/core/twas_div.sv
// ----------------------------------------------------------------------------
// Saturating serial divider
// Divides a 64-bit sum by a 32-bit weight into a 16-bit quotient that clamps
// to all ones, retiring one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twas_div
   import twas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOT_W-1:0]     rem_ff, rem_in;
   logic [TOT_W-1:0]     divisor_ff, divisor_in;
   logic [QUOT_W-1:0]    low_ff, low_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [TOT_W:0]       trial;
   logic [TOT_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, low_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      if (div_req.start) begin
         if (div_req.dividend[SUM_W-1:QUOT_W]
             >= {{(SUM_W-QUOT_W-TOT_W){1'b0}}, div_req.divisor}) begin
            quot_in = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in     = div_req.dividend[TOT_W+QUOT_W-1:QUOT_W];
            low_in     = div_req.dividend[QUOT_W-1:0];
            divisor_in = div_req.divisor;
            quot_in    = '0;
            cnt_in     = DIV_CNT_W'(QUOT_W);
            busy_in    = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
         low_in  = {low_ff[QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule
